// ===== hdl/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg: shared types and codes for the ordered list store
// Command, status and cell operation codes plus the control word that the
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package olst_pkg;

   // Broadcast index width; covers counts up to 127 elements
   localparam int unsigned IDX_W = 7;

   // Command codes
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd1;
   localparam logic [2:0] CMD_INS_AT    = 3'd2;
   localparam logic [2:0] CMD_DEL_AT    = 3'd3;
   localparam logic [2:0] CMD_INS_END   = 3'd4;
   localparam logic [2:0] CMD_DEL_END   = 3'd5;
   localparam logic [2:0] CMD_READ_ALL  = 3'd6;
   localparam logic [2:0] CMD_SEARCH    = 3'd7;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // Cell operations
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_INS  = 2'd1;
   localparam logic [1:0] CELL_DEL  = 2'd2;
   localparam logic [1:0] CELL_ROT  = 2'd3;

   // Control word seen by every cell
   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] pos;   // insert/delete position
      logic [IDX_W-1:0] last;  // index of the last occupied cell
   } cell_ctl_type;

endpackage

// ===== hdl/olst_cell.sv =====
// ----------------------------------------------------------------------------
// olst_cell: one storage cell of the ordered list
// Holds one element and takes its next value from a neighbor, the insert
// value or the head of the list, as the broadcast control word selects.
// ----------------------------------------------------------------------------
module olst_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                       clock,
   input  olst_pkg::cell_ctl_type     ctl,
   input  logic signed [31:0]         prev_value,
   input  logic signed [31:0]         next_value,
   input  logic signed [31:0]         head_value,
   input  logic signed [31:0]         ins_value,
   output logic signed [31:0]         cell_value
);

   localparam logic [olst_pkg::IDX_W-1:0] MY_IDX = olst_pkg::IDX_W'(INDEX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   // Neighbor selection
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         olst_pkg::CELL_INS: begin
            if (MY_IDX > ctl.pos) begin
               data_in = prev_value;
            end else if (MY_IDX == ctl.pos) begin
               data_in = ins_value;
            end
         end
         olst_pkg::CELL_DEL: begin
            if (MY_IDX >= ctl.pos) begin
               data_in = next_value;
            end
         end
         olst_pkg::CELL_ROT: begin
            if (MY_IDX < ctl.last) begin
               data_in = next_value;
            end else if (MY_IDX == ctl.last) begin
               data_in = head_value;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // Element storage, no reset: read only once written
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_value = data_ff;

endmodule

// ===== hdl/ordered_list_store_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_top: bounded ordered list of signed 32-bit values
// A row of CAPACITY cells holds the elements in order; a small controller
// checks each command, broadcasts shift or rotate operations to the cells
// and drives the result port.
// ----------------------------------------------------------------------------
// Usage: pulse start with a command while busy is low. Insert, delete, and a
// read-all or search of an empty list pass through the execute state, which
// checks the command and shifts every cell at once, then return to idle. A
// read-all or search of a list of N elements then enters the rotate state: the
// cells rotate toward the head once per cycle, one step per element, so the list
// ends up in its original order. Read-all gives one result per cycle, element 0
// first, the last one flagged. Search gives one result after the rotation. Results
// appear on rsp_* for exactly one cycle with rsp_strobe high; the receiver
// cannot stall them, so it must take every strobed transfer.
// ----------------------------------------------------------------------------
module ordered_list_store_top #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_item_value,
   output logic [3:0]         rsp_item_position,
   output logic               rsp_last
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned SW = $clog2(CAPACITY);
   localparam int unsigned XW = olst_pkg::IDX_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_ROT  = 2'd2;

   // Control registers
   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               found_ff, found_in;
   logic [SW-1:0]      found_pos_ff, found_pos_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   // Command and result payload
   logic [2:0]         cmd_ff;
   logic signed [31:0] value_ff;
   logic [4:0]         pos_ff;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_item_value_ff, rsp_item_value_in;
   logic [3:0]         rsp_item_position_ff, rsp_item_position_in;
   logic               rsp_last_ff, rsp_last_in;

   olst_pkg::cell_ctl_type ctl;
   logic signed [31:0]     cell_value [CAPACITY];

   logic [XW-1:0] count_x;
   logic [XW-1:0] last_idx;
   logic [XW-1:0] eff_pos;
   logic          is_full;
   logic          is_empty;
   logic          at_last;
   logic          head_match;
   logic          accept;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign count_x  = XW'(count_ff);
   assign last_idx = count_x - XW'(1);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign at_last  = (XW'(step_ff) == last_idx);
   assign head_match = (cell_value[0] == value_ff);

   // Effective position of the command
   always_comb begin
      case (cmd_ff)
         olst_pkg::CMD_INS_AT, olst_pkg::CMD_DEL_AT: eff_pos = XW'(pos_ff);
         olst_pkg::CMD_INS_END:                      eff_pos = count_x;
         olst_pkg::CMD_DEL_END:                      eff_pos = last_idx;
         default:                                    eff_pos = '0;
      endcase
   end

   // Command sequencer
   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      step_in              = step_ff;
      found_in             = found_ff;
      found_pos_in         = found_pos_ff;
      ctl.op               = olst_pkg::CELL_HOLD;
      ctl.pos              = eff_pos;
      ctl.last             = last_idx;
      rsp_strobe_in        = 1'b0;
      rsp_status_in        = olst_pkg::ST_OK;
      rsp_item_value_in    = '0;
      rsp_item_position_in = '0;
      rsp_last_in          = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (cmd_ff)
               olst_pkg::CMD_INS_FRONT, olst_pkg::CMD_INS_AT,
               olst_pkg::CMD_INS_END: begin
                  rsp_strobe_in = 1'b1;
                  if (is_full) begin
                     rsp_status_in = olst_pkg::ST_FULL;
                  end else if (eff_pos > count_x) begin
                     rsp_status_in = olst_pkg::ST_RANGE;
                  end else begin
                     ctl.op   = olst_pkg::CELL_INS;
                     count_in = count_ff + CW'(1);
                  end
               end
               olst_pkg::CMD_DEL_FRONT, olst_pkg::CMD_DEL_AT,
               olst_pkg::CMD_DEL_END: begin
                  rsp_strobe_in = 1'b1;
                  if (is_empty) begin
                     rsp_status_in = olst_pkg::ST_EMPTY;
                  end else if (eff_pos >= count_x) begin
                     rsp_status_in = olst_pkg::ST_RANGE;
                  end else begin
                     ctl.op   = olst_pkg::CELL_DEL;
                     count_in = count_ff - CW'(1);
                  end
               end
               default: begin
                  // read-all and search
                  if (is_empty) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = olst_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_ROT;
                     step_in  = '0;
                     found_in = 1'b0;
                  end
               end
            endcase
         end
         S_ROT: begin
            ctl.op = olst_pkg::CELL_ROT;
            if (cmd_ff == olst_pkg::CMD_READ_ALL) begin
               rsp_strobe_in        = 1'b1;
               rsp_item_value_in    = cell_value[0];
               rsp_item_position_in = 4'(step_ff);
               rsp_last_in          = at_last;
            end else begin
               if (head_match && !found_ff) begin
                  found_in     = 1'b1;
                  found_pos_in = step_ff;
               end
               if (at_last) begin
                  rsp_strobe_in = 1'b1;
                  if (found_ff) begin
                     rsp_item_position_in = 4'(found_pos_ff);
                  end else if (head_match) begin
                     rsp_item_position_in = 4'(step_ff);
                  end else begin
                     rsp_status_in = olst_pkg::ST_NOTFOUND;
                  end
               end
            end
            if (at_last) begin
               state_in = S_IDLE;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         found_pos_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         found_pos_ff  <= found_pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Command capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      rsp_status_ff        <= rsp_status_in;
      rsp_item_value_ff    <= rsp_item_value_in;
      rsp_item_position_ff <= rsp_item_position_in;
      rsp_last_ff          <= rsp_last_in;
   end

   // Row of storage cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] prev_v;
      logic signed [31:0] next_v;
      if (i == 0) begin : g_first
         assign prev_v = value_ff;
      end else begin : g_mid_prev
         assign prev_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_lastc
         assign next_v = cell_value[i];
      end else begin : g_mid_next
         assign next_v = cell_value[i+1];
      end
      olst_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .prev_value (prev_v),
         .next_value (next_v),
         .head_value (cell_value[0]),
         .ins_value  (value_ff),
         .cell_value (cell_value[i])
      );
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_item_value    = rsp_item_value_ff;
   assign rsp_item_position = rsp_item_position_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
